// ===== rtl/core/stack_machine_execute_defines.svh =====
// ----------------------------------------------------------------------------
// Stack machine execute assertion macros
// Concurrent assertion helpers that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTE_DEFINES_SVH
`define STACK_MACHINE_EXECUTE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SME_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SME_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SME_ASSERT_IMPL(label, clk, rst, prop, msg)
`define SME_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/sme_pkg.sv =====
// ----------------------------------------------------------------------------
// Stack machine execute package
// Shared constants, opcode and error codes, controller state and command types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package sme_pkg;
   localparam int STACK_DEPTH = 256;
   localparam int MEM_WORDS   = 1024;
   localparam int PC_BITS     = 16;
   localparam int SP_BITS     = $clog2(STACK_DEPTH + 1);
   localparam int SA_BITS     = $clog2(STACK_DEPTH);
   localparam int MA_BITS     = $clog2(MEM_WORDS);
   localparam int MC_BITS     = $clog2(MEM_WORDS + 1);
   localparam int LEN_BITS    = 17;

   localparam logic [3:0] OP_POP = 4'd0, OP_PUSH = 4'd1, OP_LOAD = 4'd2, OP_ADD = 4'd3,
      OP_SUB = 4'd4, OP_MUL = 4'd5, OP_DIV = 4'd6, OP_PRINT = 4'd7, OP_NOT = 4'd8,
      OP_CMP = 4'd9, OP_JMP = 4'd10, OP_JMPIF = 4'd11, OP_STORE = 4'd12;

   localparam logic [2:0] ERR_OK = 3'd0, ERR_UNDER = 3'd1, ERR_OVER = 3'd2,
      ERR_DIVZ = 3'd3, ERR_ADDR = 3'd4, ERR_JUMP = 3'd5, ERR_CMP = 3'd6;

   localparam logic [2:0] CMP_LT = 3'd0, CMP_LE = 3'd1, CMP_EQ = 3'd2, CMP_NE = 3'd3,
      CMP_GE = 3'd4, CMP_GT = 3'd5;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_CHECK, ST_MEMRD, ST_MUL, ST_DIV, ST_WRITE, ST_OUT
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic clear_step;
      logic capture;
      logic read_stack;
      logic check;
      logic mem_read;
      logic mul_start;
      logic div_start;
      logic commit;
      logic rsp_load;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic clear_done;
      logic need_mem;
      logic need_mul;
      logic need_div;
      logic mul_done;
      logic div_done;
      logic fail;
   } sts_type;
endpackage

// ===== rtl/core/sme_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sme_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/sme_ctrl.sv =====
// ----------------------------------------------------------------------------
// Stack machine execute controller
// Sequences clearing, stack read, checks, memory and arithmetic, commit, output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stack_machine_execute_defines.svh"
module sme_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               rsp_busy,
   input  sme_pkg::sts_type   sts,
   output sme_pkg::cmd_type   cmd
);
   sme_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sme_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sme_pkg::ST_CLEAR: if (sts.clear_done) state_in = sme_pkg::ST_IDLE;
         sme_pkg::ST_IDLE:  if (req_valid) state_in = sme_pkg::ST_READ;
         sme_pkg::ST_READ:  state_in = sme_pkg::ST_CHECK;
         sme_pkg::ST_CHECK: begin
            if (sts.fail)          state_in = sme_pkg::ST_WRITE;
            else if (sts.need_mem) state_in = sme_pkg::ST_MEMRD;
            else if (sts.need_mul) state_in = sme_pkg::ST_MUL;
            else if (sts.need_div) state_in = sme_pkg::ST_DIV;
            else                   state_in = sme_pkg::ST_WRITE;
         end
         sme_pkg::ST_MEMRD: state_in = sme_pkg::ST_WRITE;
         sme_pkg::ST_MUL:   if (sts.mul_done) state_in = sme_pkg::ST_WRITE;
         sme_pkg::ST_DIV:   if (sts.div_done) state_in = sme_pkg::ST_WRITE;
         sme_pkg::ST_WRITE: state_in = sme_pkg::ST_OUT;
         sme_pkg::ST_OUT:   if (!rsp_busy) state_in = sme_pkg::ST_IDLE;
         default:           state_in = sme_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         sme_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
         sme_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         sme_pkg::ST_READ:  cmd.read_stack = 1'b1;
         sme_pkg::ST_CHECK: begin
            cmd.check     = 1'b1;
            cmd.mul_start = !sts.fail && !sts.need_mem && sts.need_mul;
            cmd.div_start = !sts.fail && !sts.need_mem && !sts.need_mul && sts.need_div;
         end
         sme_pkg::ST_MEMRD: cmd.mem_read = 1'b1;
         sme_pkg::ST_WRITE: cmd.commit = 1'b1;
         sme_pkg::ST_OUT:   cmd.rsp_load = !rsp_busy;
         default: ;
      endcase
   end

   `SME_ASSERT_IMPL(a_one_cmd, clock, reset,
      $countones({cmd.capture, cmd.commit, cmd.rsp_load}) <= 1, "overlapping commands")
   `SME_ASSERT_IMPL(a_commit_then_out, clock, reset,
      cmd.commit |=> state_ff == sme_pkg::ST_OUT, "commit not followed by output")
   `SME_ASSERT_IMPL(a_stall_busy, clock, reset,
      state_ff != sme_pkg::ST_IDLE |-> req_stall, "accepting while busy")
endmodule

// ===== rtl/core/sme_dpath.sv =====
// ----------------------------------------------------------------------------
// Stack machine execute datapath
// Stack and data memories, pointers, checks, multiplier and divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stack_machine_execute_defines.svh"
module sme_dpath (
   input  logic                        clock,
   input  logic                        reset,
   input  sme_pkg::cmd_type            cmd,
   output sme_pkg::sts_type            sts,
   input  logic                        csr_write,
   input  logic [sme_pkg::LEN_BITS-1:0] csr_wdata,
   input  logic [3:0]                  req_opcode,
   input  logic signed [63:0]          req_operand,
   output logic [15:0]                 rsp_next_pc,
   output logic                        rsp_halted,
   output logic                        rsp_print_valid,
   output logic signed [63:0]          rsp_print_value,
   output logic [2:0]                  rsp_error_code
);
   localparam int SP = sme_pkg::SP_BITS;
   localparam int SA = sme_pkg::SA_BITS;
   localparam int MA = sme_pkg::MA_BITS;
   localparam int PB = sme_pkg::PC_BITS;

   logic [sme_pkg::LEN_BITS-1:0] len_ff;
   logic [SP-1:0] sp_ff, sp_in;
   logic [PB-1:0] pc_ff, pc_in;
   logic          halt_ff, halt_in;
   logic [3:0]    op_ff;
   logic [63:0]   arg_ff;
   logic [63:0]   a_ff, b_ff;
   logic [63:0]   res_ff, res_in;
   logic [2:0]    err_ff, err_in;
   logic          pv_ff;
   logic [sme_pkg::MC_BITS-1:0] clr_ff;
   logic [63:0]   rsp_pv_ff;
   logic [15:0]   rsp_pc_ff;
   logic          rsp_h_ff, rsp_pvld_ff;
   logic [2:0]    rsp_e_ff;

   // Stack RAMs: two copies so the top and second entries read together.
   logic          st_we;
   logic [SA-1:0] st_wa;
   logic [63:0]   st_wd, st_top, st_sec;
   logic [SA-1:0] ra_top, ra_sec;

   assign ra_top = SA'(sp_ff - SP'(1));
   assign ra_sec = SA'(sp_ff - SP'(2));

   sme_ram #(.WIDTH(64), .DEPTH(sme_pkg::STACK_DEPTH)) u_stack_top (
      .clock, .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
      .rd_addr(ra_top), .rd_data(st_top));
   sme_ram #(.WIDTH(64), .DEPTH(sme_pkg::STACK_DEPTH)) u_stack_sec (
      .clock, .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
      .rd_addr(ra_sec), .rd_data(st_sec));

   // Data memory.
   logic          dm_we;
   logic [MA-1:0] dm_wa, dm_ra;
   logic [63:0]   dm_wd, dm_rd;
   sme_ram #(.WIDTH(64), .DEPTH(sme_pkg::MEM_WORDS)) u_dmem (
      .clock, .wr_en(dm_we), .wr_addr(dm_wa), .wr_data(dm_wd),
      .rd_addr(dm_ra), .rd_data(dm_rd));

   assign dm_ra = MA'(a_ff);

   // Checks, evaluated in the check state from registered operands.
   logic under, over, tgt_ok, addr_bad, cmp_bad, divz, halting;
   logic [63:0] addr_chk;
   logic lt_ba, eq_ba;
   logic [63:0] alu;

   always_comb begin
      tgt_ok = !arg_ff[63] && arg_ff != 64'd0
         && arg_ff < 64'(len_ff) && arg_ff <= 64'({PB{1'b1}});
      addr_chk = (op_ff == sme_pkg::OP_STORE) ? b_ff : a_ff;
      addr_bad = addr_chk >= 64'(sme_pkg::MEM_WORDS);
      cmp_bad  = arg_ff > 64'd5;
      divz     = a_ff == 64'd0;
      over     = sp_ff >= SP'(sme_pkg::STACK_DEPTH);
      halting  = op_ff > sme_pkg::OP_STORE;
      case (op_ff)
         sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
         sme_pkg::OP_CMP, sme_pkg::OP_STORE: under = sp_ff < SP'(2);
         sme_pkg::OP_POP, sme_pkg::OP_LOAD, sme_pkg::OP_PRINT, sme_pkg::OP_NOT,
         sme_pkg::OP_JMPIF: under = sp_ff < SP'(1);
         default: under = 1'b0;
      endcase
      err_in = sme_pkg::ERR_OK;
      case (op_ff)
         sme_pkg::OP_PUSH: if (over) err_in = sme_pkg::ERR_OVER;
         sme_pkg::OP_LOAD, sme_pkg::OP_STORE: begin
            if (under) err_in = sme_pkg::ERR_UNDER;
            else if (addr_bad) err_in = sme_pkg::ERR_ADDR;
         end
         sme_pkg::OP_DIV: begin
            if (under) err_in = sme_pkg::ERR_UNDER;
            else if (divz) err_in = sme_pkg::ERR_DIVZ;
         end
         sme_pkg::OP_CMP: begin
            if (under) err_in = sme_pkg::ERR_UNDER;
            else if (cmp_bad) err_in = sme_pkg::ERR_CMP;
         end
         sme_pkg::OP_JMP: if (!tgt_ok) err_in = sme_pkg::ERR_JUMP;
         sme_pkg::OP_JMPIF: begin
            if (!tgt_ok) err_in = sme_pkg::ERR_JUMP;
            else if (under) err_in = sme_pkg::ERR_UNDER;
         end
         default: if (under) err_in = sme_pkg::ERR_UNDER;
      endcase
      lt_ba = $signed(b_ff) < $signed(a_ff);
      eq_ba = b_ff == a_ff;
      alu = 64'd0;
      case (op_ff)
         sme_pkg::OP_ADD: alu = b_ff + a_ff;
         sme_pkg::OP_SUB: alu = b_ff - a_ff;
         sme_pkg::OP_NOT: alu = {63'd0, a_ff == 64'd0};
         sme_pkg::OP_CMP: begin
            case (arg_ff[2:0])
               sme_pkg::CMP_LT: alu = {63'd0, lt_ba};
               sme_pkg::CMP_LE: alu = {63'd0, lt_ba || eq_ba};
               sme_pkg::CMP_EQ: alu = {63'd0, eq_ba};
               sme_pkg::CMP_NE: alu = {63'd0, !eq_ba};
               sme_pkg::CMP_GE: alu = {63'd0, !lt_ba};
               default:         alu = {63'd0, !lt_ba && !eq_ba};
            endcase
         end
         default: alu = a_ff;
      endcase
   end

   logic ok;
   assign ok = !halt_ff && err_in == sme_pkg::ERR_OK && !halting;
   assign sts.fail     = !ok;
   assign sts.need_mem = op_ff == sme_pkg::OP_LOAD;
   assign sts.need_mul = op_ff == sme_pkg::OP_MUL;
   assign sts.need_div = op_ff == sme_pkg::OP_DIV;

   // Multiplier: four 64x16 partial products, one per cycle.
   logic [63:0] mul_acc_ff;
   logic [1:0]  mul_cnt_ff;
   logic        mul_run_ff;
   logic [63:0] mul_pp;
   assign mul_pp = b_ff * 64'(a_ff[16*mul_cnt_ff +: 16]);
   assign sts.mul_done = mul_run_ff && mul_cnt_ff == 2'd3;

   // Divider: restoring, one quotient bit per cycle on magnitudes.
   logic [63:0] dv_rem_ff, dv_quo_ff, dv_den_ff;
   logic [6:0]  dv_cnt_ff;
   logic        dv_neg_ff, dv_run_ff;
   logic [64:0] dv_sh, dv_diff;
   assign dv_sh   = {dv_rem_ff, dv_quo_ff[63]};
   assign dv_diff = dv_sh - {1'b0, dv_den_ff};
   assign sts.div_done = dv_run_ff && dv_cnt_ff == 7'd64;

   assign sts.clear_done = clr_ff == sme_pkg::MC_BITS'(sme_pkg::MEM_WORDS - 1);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_opcode;
         arg_ff <= req_operand;
      end
      // The stack read data is already valid in the read state, since the
      // pointer has been stable since the previous commit.
      if (cmd.read_stack) begin
         a_ff <= st_top;
         b_ff <= st_sec;
      end
      if (cmd.check || cmd.mem_read || mul_run_ff || dv_run_ff) begin
         res_ff <= res_in;
      end
      if (cmd.check) begin
         err_ff <= halt_ff ? sme_pkg::ERR_OK : err_in;
         pv_ff  <= ok && op_ff == sme_pkg::OP_PRINT;
      end
      if (cmd.mul_start) begin
         mul_acc_ff <= '0;
      end else if (mul_run_ff) begin
         mul_acc_ff <= mul_acc_ff + (mul_pp << (16 * mul_cnt_ff));
      end
      if (cmd.div_start) begin
         dv_rem_ff <= '0;
         dv_quo_ff <= st_sec[63] ? -st_sec : st_sec;
         dv_den_ff <= st_top[63] ? -st_top : st_top;
         dv_neg_ff <= st_sec[63] ^ st_top[63];
      end else if (dv_run_ff && !sts.div_done) begin
         if (!dv_diff[64]) begin
            dv_rem_ff <= dv_diff[63:0];
            dv_quo_ff <= {dv_quo_ff[62:0], 1'b1};
         end else begin
            dv_rem_ff <= dv_sh[63:0];
            dv_quo_ff <= {dv_quo_ff[62:0], 1'b0};
         end
      end
      if (cmd.rsp_load) begin
         rsp_pc_ff   <= 16'(pc_ff);
         rsp_h_ff    <= halt_ff;
         rsp_pvld_ff <= pv_ff;
         rsp_pv_ff   <= pv_ff ? res_ff : 64'd0;
         rsp_e_ff    <= err_ff;
      end
   end

   // The check state sees the operands the cycle after the stack read.
   always_comb begin
      res_in = res_ff;
      if (cmd.check) begin
         res_in = st_top;
      end else if (cmd.mem_read) begin
         res_in = res_ff;
      end
      if (mul_run_ff) res_in = mul_acc_ff + (mul_pp << (16 * mul_cnt_ff));
      if (dv_run_ff) res_in = dv_neg_ff ? -dv_quo_ff : dv_quo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= sme_pkg::LEN_BITS'(65536);
         sp_ff      <= '0;
         pc_ff      <= '0;
         halt_ff    <= 1'b0;
         clr_ff     <= '0;
         mul_run_ff <= 1'b0;
         mul_cnt_ff <= '0;
         dv_run_ff  <= 1'b0;
         dv_cnt_ff  <= '0;
      end else begin
         if (csr_write) len_ff <= csr_wdata;
         if (cmd.clear_step && !sts.clear_done) clr_ff <= clr_ff + 1'b1;
         sp_ff   <= sp_in;
         pc_ff   <= pc_in;
         halt_ff <= halt_in;
         if (cmd.mul_start) begin
            mul_run_ff <= 1'b1;
            mul_cnt_ff <= '0;
         end else if (mul_run_ff) begin
            mul_cnt_ff <= mul_cnt_ff + 1'b1;
            if (sts.mul_done) mul_run_ff <= 1'b0;
         end
         if (cmd.div_start) begin
            dv_run_ff <= 1'b1;
            dv_cnt_ff <= '0;
         end else if (dv_run_ff) begin
            dv_cnt_ff <= dv_cnt_ff + 1'b1;
            if (sts.div_done) dv_run_ff <= 1'b0;
         end
      end
   end

   // Load reads memory in the check cycle; data arrives for the memory state.
   logic [63:0] wval;
   logic        ld_ff;
   always_ff @(posedge clock) begin
      ld_ff <= cmd.mem_read;
   end

   always_comb begin
      sp_in   = sp_ff;
      pc_in   = pc_ff;
      halt_in = halt_ff;
      st_we   = 1'b0;
      st_wa   = ra_top;
      wval    = res_ff;
      dm_we   = cmd.clear_step;
      dm_wa   = MA'(clr_ff);
      dm_wd   = 64'd0;
      if (cmd.commit) begin
         if (err_ff != sme_pkg::ERR_OK || (op_ff > sme_pkg::OP_STORE && !halt_ff)) begin
            halt_in = 1'b1;
         end else if (!halt_ff) begin
            pc_in = pc_ff + PB'(1);
            case (op_ff)
               sme_pkg::OP_POP, sme_pkg::OP_PRINT: sp_in = sp_ff - SP'(1);
               sme_pkg::OP_PUSH: begin
                  st_we = 1'b1;
                  st_wa = SA'(sp_ff);
                  wval  = arg_ff;
                  sp_in = sp_ff + SP'(1);
               end
               sme_pkg::OP_LOAD: begin
                  st_we = 1'b1;
                  wval  = dm_rd;
               end
               sme_pkg::OP_NOT: begin
                  st_we = 1'b1;
                  wval  = {63'd0, a_ff == 64'd0};
               end
               sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_CMP: begin
                  st_we = 1'b1;
                  st_wa = ra_sec;
                  wval  = alu;
                  sp_in = sp_ff - SP'(1);
               end
               sme_pkg::OP_MUL, sme_pkg::OP_DIV: begin
                  st_we = 1'b1;
                  st_wa = ra_sec;
                  sp_in = sp_ff - SP'(1);
               end
               sme_pkg::OP_JMP: pc_in = PB'(arg_ff);
               sme_pkg::OP_JMPIF: begin
                  sp_in = sp_ff - SP'(1);
                  if (a_ff != 64'd0) pc_in = PB'(arg_ff);
               end
               sme_pkg::OP_STORE: begin
                  dm_we = 1'b1;
                  dm_wa = MA'(b_ff);
                  dm_wd = a_ff;
                  sp_in = sp_ff - SP'(2);
               end
               default: ;
            endcase
         end
      end
   end
   assign st_wd = wval;

   assign rsp_next_pc     = rsp_pc_ff;
   assign rsp_halted      = rsp_h_ff;
   assign rsp_print_valid = rsp_pvld_ff;
   assign rsp_print_value = rsp_pv_ff;
   assign rsp_error_code  = rsp_e_ff;

   `SME_ASSERT_IMPL(a_sp_range, clock, reset,
      sp_ff <= SP'(sme_pkg::STACK_DEPTH), "stack pointer out of range")
   `SME_ASSERT_IMPL(a_halt_sticky, clock, reset,
      halt_ff |=> halt_ff, "halt flag dropped")
   `SME_ASSERT_IMPL(a_ld_order, clock, reset,
      ld_ff |-> !cmd.mem_read, "memory read repeated")
endmodule

// ===== rtl/core/stack_machine_execute.sv =====
// ----------------------------------------------------------------------------
// Stack machine execute
// Top level: one instruction per input item against stack, memory and pc.
// ----------------------------------------------------------------------------
// Usage: drive req_opcode and req_operand with req_valid; the item is taken
// at an edge where req_valid is high and req_stall is low. Each item yields
// exactly one result item on the rsp_ channel (next pc, halted, print value,
// error code), taken when rsp_valid is high and rsp_stall is low.
// From the accepting edge the item passes the read and check states, then a
// memory state for load, the multiply state for multiply (four 16-bit partial
// product steps) or the divide state for divide (64 quotient bits, one per
// cycle), then the write state and the output state. Only one item is in
// flight; the next item is taken in the cycle after the previous result has
// moved into the output register.
// After reset the data memory is cleared, one word a cycle for all 1024 words,
// during which req_stall stays high. csr_write updates the program length
// register at any time the block is idle.
// A stalled result holds its value; the next item may still be taken meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module stack_machine_execute (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [16:0]        csr_program_length,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_opcode,
   input  logic signed [63:0] req_operand,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_next_pc,
   output logic               rsp_halted,
   output logic               rsp_print_valid,
   output logic signed [63:0] rsp_print_value,
   output logic [2:0]         rsp_error_code
);
   sme_pkg::cmd_type cmd;
   sme_pkg::sts_type sts;
   logic rsp_valid_ff;
   logic rsp_busy;

   // Output register is busy while an untaken result sits in it.
   assign rsp_busy = rsp_valid_ff && rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end
   assign rsp_valid = rsp_valid_ff;

   sme_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_busy, .sts, .cmd);

   sme_dpath u_dpath (
      .clock, .reset, .cmd, .sts, .csr_write, .csr_wdata(csr_program_length),
      .req_opcode, .req_operand, .rsp_next_pc, .rsp_halted, .rsp_print_valid,
      .rsp_print_value, .rsp_error_code);
endmodule
